FILE: src/lobm_pkg.sv
// ============================================================================
// lobm_pkg
// Shared types and constants for the limit order book matcher.
// ============================================================================
package lobm_pkg;

    localparam int ORDER_SLOTS_DEF = 32;
    localparam int MAX_RESULTS     = 35;

    localparam logic [1:0] KIND_TRADE   = 2'd0;
    localparam logic [1:0] KIND_BATTERY = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [39:0] BAL_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] E32_MAX = 32'hFFFF_FFFF;

    // One stored order; the slot's valid bit is kept apart in flip-flops.
    typedef struct packed {
        logic        is_buy;
        logic [15:0] node;
        logic [31:0] energy;
        logic [31:0] price;
        logic [7:0]  seq;
    } order_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seller_id;
        logic [15:0] buyer_id;
        logic [31:0] energy_wh_res;
        logic [31:0] unit_price;
        logic [6:0]  trade_count;
        logic [39:0] battery_balance;
        logic        overflow;
        logic        last;
    } result_t;

    // Scan request from the sequencer to the shared compare unit.
    typedef struct packed {
        logic start;
        logic want_buy;
        logic skip_battery;
    } scan_req_t;

endpackage

FILE: src/lobm_scan.sv
// ============================================================================
// lobm_scan
// Shared best-order compare unit: walks the slots one per cycle.
// ============================================================================
module lobm_scan #(
    parameter int NSLOT = 33
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lobm_pkg::scan_req_t          req,
    input  logic                         slot_valid,
    input  lobm_pkg::order_t             slot_data,
    output logic [$clog2(NSLOT+1)-1:0]   addr,
    output logic                         done,
    output logic                         found,
    output logic [$clog2(NSLOT)-1:0]     best_idx,
    output lobm_pkg::order_t             best
);
    import lobm_pkg::*;

    localparam int IW = $clog2(NSLOT);
    localparam int CW = $clog2(NSLOT + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic          want_reg, skip_reg;
    logic          found_reg, found_next;
    logic          done_reg, done_next;
    logic [IW-1:0] idx_reg, idx_next;
    order_t        best_reg, best_next;
    logic          better;
    logic          take;

    // The slot read now was addressed in the previous cycle (registered read).
    logic          rd_live_reg;
    logic [CW-1:0] rd_addr_reg;

    always_comb
    begin
        if (slot_data.price == best_reg.price)
            better = slot_data.seq < best_reg.seq;
        else if (want_reg)
            better = slot_data.price > best_reg.price;
        else
            better = slot_data.price < best_reg.price;
        take = rd_live_reg && slot_valid && (slot_data.is_buy == want_reg)
            && !(skip_reg && (rd_addr_reg == CW'(NSLOT - 1)))
            && (!found_reg || better);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        addr_next  = addr_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        done_next  = 1'b0;
        if (req.start) begin
            busy_next  = 1'b1;
            addr_next  = '0;
            found_next = 1'b0;
        end else begin
            if (take) begin
                found_next = 1'b1;
                idx_next   = rd_addr_reg[IW-1:0];
                best_next  = slot_data;
            end
            if (busy_reg) begin
                if (addr_reg == CW'(NSLOT - 1))
                    busy_next = 1'b0;
                addr_next = addr_reg + CW'(1);
            end
            if (rd_live_reg && !busy_reg)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            addr_reg    <= '0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            rd_live_reg <= 1'b0;
            want_reg    <= 1'b0;
            skip_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            addr_reg    <= addr_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            rd_live_reg <= busy_reg && !req.start;
            if (req.start) begin
                want_reg <= req.want_buy;
                skip_reg <= req.skip_battery;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        rd_addr_reg <= addr_reg;
    end

    assign addr     = addr_reg;
    assign done     = done_reg;
    assign found    = found_reg;
    assign best_idx = idx_reg;
    assign best     = best_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg) else $error("scan done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("scan start lost");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("scan done held");

endmodule

FILE: src/limit_order_book_matcher.sv
// ============================================================================
// limit_order_book_matcher
// Price-time priority order book for one trading tick with a storage battery.
// ============================================================================
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  -----------------  ----------------------------------
//  input     in         in_valid/in_stall  mode is_buy node_id energy_wh
//                                          price base_price
//  result    out        out_valid/out_stall kind seller_id buyer_id ...
//  config    in         cfg_we             cfg_wdata (battery_node_id)
//
//  A load transfer is accepted in S_IDLE, then S_LOAD writes the order
//  into the lowest free slot, found by a priority search over the valid
//  bits. A run uses the shared compare unit for a bid scan and an ask
//  scan plus the S_TRADE, S_SET_B and S_SET_A steps per trade, one scan
//  per battery purchase and a final purchase scan that ends the step,
//  then the summary step and a clearing pass over the slots at the end.
//  Reset clears the valid bits, counters and battery balance at once.
//  A stalled result holds the sequencer in the trade step, or makes the
//  purchase scan run again; no new input is taken meanwhile.
// ============================================================================
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic        is_buy,
    input  logic [15:0] node_id,
    input  logic [31:0] energy_wh,
    input  logic [31:0] price,
    input  logic [31:0] base_price,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] seller_id,
    output logic [15:0] buyer_id,
    output logic [31:0] energy_wh_res,
    output logic [31:0] unit_price,
    output logic [6:0]  trade_count,
    output logic [39:0] battery_balance,
    output logic        overflow,
    output logic        last
);
    import lobm_pkg::*;

    localparam int NSLOT = ORDER_SLOTS + 1;
    localparam int IW    = $clog2(NSLOT);
    localparam int CW    = $clog2(NSLOT + 1);
    localparam logic [IW-1:0] BAT = IW'(ORDER_SLOTS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_BID   = 10'b0000000100,
        S_ASK   = 10'b0000001000,
        S_TRADE = 10'b0000010000,
        S_SET_B = 10'b0000100000,
        S_SET_A = 10'b0001000000,
        S_BUY   = 10'b0010000000,
        S_SUM   = 10'b0100000000,
        S_CLEAR = 10'b1000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [15:0]   bat_id_reg;
    logic [39:0]   bat_reg;
    logic [7:0]    arr_reg;
    logic          drop_reg;
    logic [6:0]    count_reg;
    logic [5:0]    nres_reg;
    logic [31:0]   base_reg;
    order_t        load_reg;
    logic          waiting_reg;   // scan started, result pending
    logic [NSLOT-1:0] valid_reg;

    // Order store: one write port, one registered read port.
    order_t        mem [NSLOT];
    order_t        rd_data;
    logic          rd_valid_reg;
    logic          we;
    logic [IW-1:0] waddr;
    order_t        wdata;

    scan_req_t     req;
    logic [CW-1:0] saddr;
    logic          sdone, sfound;
    logic [IW-1:0] sidx;
    order_t        sbest;

    logic [IW-1:0] bidx_reg, aidx_reg;
    order_t        bid_reg, ask_reg;
    logic          ffound_reg;
    logic [31:0]   e_reg;
    result_t       res_reg;
    logic          ovalid_reg, ovalid_next;
    logic [CW-1:0] clr_reg;

    // Free slot: lowest clear valid bit among the order slots.
    logic [IW-1:0] free_idx;
    logic          free_found;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data <= mem[(saddr < CW'(NSLOT)) ? saddr[IW-1:0] : '0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= (saddr < CW'(NSLOT)) && valid_reg[saddr[IW-1:0]];
    end

    lobm_scan #(.NSLOT(NSLOT)) u_scan (
        .clk(clk), .rst_n(rst_n), .req(req), .slot_valid(rd_valid_reg),
        .slot_data(rd_data), .addr(saddr), .done(sdone), .found(sfound),
        .best_idx(sidx), .best(sbest)
    );

    assign in_stall = (state_reg != S_IDLE);
    wire   in_fire  = in_valid && !in_stall;
    wire   out_free = !ovalid_reg || !out_stall;

    logic [32:0] sum_p;
    logic [31:0] rem;
    assign sum_p   = {1'b0, bid_reg.price} + {1'b0, ask_reg.price};

    always_comb
    begin
        req         = '0;
        we          = 1'b0;
        waddr       = bidx_reg;
        wdata       = bid_reg;
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        rem         = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (!mode) begin
                        state_next = S_LOAD;
                    end else if (bat_reg != '0) begin
                        we    = 1'b1;
                        waddr = BAT;
                        wdata = '{is_buy: 1'b0, node: bat_id_reg,
                                  energy: (bat_reg > 40'(E32_MAX)) ? E32_MAX
                                          : bat_reg[31:0],
                                  price: base_price, seq: arr_reg};
                        state_next = S_BID;
                    end else begin
                        state_next = S_BID;
                    end
                end
            end
            S_LOAD: begin
                if (free_found) begin
                    we    = 1'b1;
                    waddr = free_idx;
                    wdata = load_reg;
                end
                state_next = S_IDLE;
            end
            S_BID: begin
                if (!waiting_reg)
                    req = '{start: 1'b1, want_buy: 1'b1, skip_battery: 1'b0};
                else if (sdone)
                    state_next = S_ASK;
            end
            S_ASK: begin
                if (!waiting_reg)
                    req = '{start: 1'b1, want_buy: 1'b0, skip_battery: 1'b0};
                else if (sdone)
                    state_next = S_TRADE;
            end
            S_TRADE: begin
                if (!ffound_reg || !sfound || bid_reg.price < sbest.price
                    || nres_reg >= 6'(MAX_RESULTS - 1))
                    state_next = S_BUY;
                else if (out_free) begin
                    state_next  = S_SET_B;
                    ovalid_next = 1'b1;
                end
            end
            S_SET_B: begin
                rem = bid_reg.energy - e_reg;
                we  = rem > 32'd1;
                waddr = bidx_reg;
                wdata = bid_reg;
                wdata.energy = rem;
                wdata.seq    = arr_reg;
                state_next = S_SET_A;
            end
            S_SET_A: begin
                rem = ask_reg.energy - e_reg;
                we  = rem > 32'd1;
                waddr = aidx_reg;
                wdata = ask_reg;
                wdata.energy = rem;
                wdata.seq    = arr_reg;
                state_next = S_BID;
            end
            S_BUY: begin
                if (!waiting_reg)
                    req = '{start: 1'b1, want_buy: 1'b0, skip_battery: 1'b1};
                else if (sdone) begin
                    if (!sfound || nres_reg >= 6'(MAX_RESULTS - 1))
                        state_next = S_SUM;
                    else if (out_free)
                        ovalid_next = 1'b1;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    state_next  = S_CLEAR;
                    ovalid_next = 1'b1;
                end
            end
            S_CLEAR: begin
                if (clr_reg == CW'(NSLOT - 1))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx   = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            bat_id_reg  <= '0;
            bat_reg     <= '0;
            arr_reg     <= '0;
            drop_reg    <= 1'b0;
            count_reg   <= '0;
            nres_reg    <= '0;
            waiting_reg <= 1'b0;
            valid_reg   <= '0;
            ovalid_reg  <= 1'b0;
            ffound_reg  <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                bat_id_reg <= cfg_wdata;
            if (req.start)
                waiting_reg <= 1'b1;
            else if (sdone)
                waiting_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_fire && mode) begin
                        count_reg <= '0;
                        nres_reg  <= '0;
                        if (bat_reg != '0) begin
                            valid_reg[BAT] <= 1'b1;
                            arr_reg        <= arr_reg + 8'd1;
                        end
                    end
                end
                S_LOAD: begin
                    if (free_found) begin
                        valid_reg[free_idx] <= 1'b1;
                        arr_reg <= arr_reg + 8'd1;
                    end else begin
                        drop_reg <= 1'b1;
                    end
                end
                S_BID: begin
                    if (waiting_reg && sdone)
                        ffound_reg <= sfound;
                end
                S_TRADE: begin
                    if (state_next == S_SET_B) begin
                        count_reg  <= count_reg + 7'd1;
                        nres_reg   <= nres_reg + 6'd1;
                        if (aidx_reg == BAT)
                            bat_reg <= (bat_reg >= 40'(e_reg)) ? bat_reg - 40'(e_reg)
                                                                : '0;
                    end
                end
                S_SET_B: begin
                    if (rem > 32'd1)
                        arr_reg <= arr_reg + 8'd1;
                    else
                        valid_reg[bidx_reg] <= 1'b0;
                end
                S_SET_A: begin
                    if (rem > 32'd1)
                        arr_reg <= arr_reg + 8'd1;
                    else
                        valid_reg[aidx_reg] <= 1'b0;
                end
                S_BUY: begin
                    // With the output register busy, the scan simply runs again.
                    if (waiting_reg && sdone && sfound
                        && nres_reg < 6'(MAX_RESULTS - 1) && out_free) begin
                        nres_reg   <= nres_reg + 6'd1;
                        valid_reg[sidx] <= 1'b0;
                        bat_reg <= ({1'b0, bat_reg} + 41'(sbest.energy) > 41'(BAL_MAX))
                                   ? BAL_MAX : bat_reg + 40'(sbest.energy);
                    end
                end
                S_SUM: begin
                    if (out_free)
                        clr_reg <= '0;
                end
                S_CLEAR: begin
                    clr_reg <= clr_reg + CW'(1);
                    if (state_next == S_IDLE) begin
                        valid_reg <= '0;
                        arr_reg   <= '0;
                        drop_reg  <= 1'b0;
                    end else begin
                        valid_reg[clr_reg[IW-1:0]] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            base_reg <= base_price;
            load_reg <= '{is_buy: is_buy, node: node_id, energy: energy_wh,
                          price: price, seq: arr_reg};
        end
        if (state_reg == S_LOAD)
            load_reg.seq <= arr_reg;
        if (state_reg == S_BID && waiting_reg && sdone) begin
            bid_reg  <= sbest;
            bidx_reg <= sidx;
        end
        if (state_reg == S_ASK && waiting_reg && sdone) begin
            ask_reg  <= sbest;
            aidx_reg <= sidx;
            e_reg    <= (bid_reg.energy < sbest.energy) ? bid_reg.energy : sbest.energy;
        end
        if (state_reg == S_TRADE && state_next == S_SET_B)
            res_reg <= '{kind: KIND_TRADE, seller_id: ask_reg.node,
                         buyer_id: bid_reg.node, energy_wh_res: e_reg,
                         unit_price: sum_p[32:1], trade_count: '0,
                         battery_balance: '0, overflow: 1'b0, last: 1'b0};
        if (state_reg == S_BUY && waiting_reg && sdone && sfound && out_free)
            res_reg <= '{kind: KIND_BATTERY, seller_id: sbest.node,
                         buyer_id: bat_id_reg, energy_wh_res: sbest.energy,
                         unit_price: base_reg, trade_count: '0,
                         battery_balance: '0, overflow: 1'b0, last: 1'b0};
        if (state_reg == S_SUM && out_free)
            res_reg <= '{kind: KIND_SUMMARY, seller_id: '0, buyer_id: '0,
                         energy_wh_res: '0, unit_price: '0,
                         trade_count: count_reg, battery_balance: bat_reg,
                         overflow: drop_reg, last: 1'b1};
    end

    assign out_valid       = ovalid_reg;
    assign kind            = res_reg.kind;
    assign seller_id       = res_reg.seller_id;
    assign buyer_id        = res_reg.buyer_id;
    assign energy_wh_res   = res_reg.energy_wh_res;
    assign unit_price      = res_reg.unit_price;
    assign trade_count     = res_reg.trade_count;
    assign battery_balance = res_reg.battery_balance;
    assign overflow        = res_reg.overflow;
    assign last            = res_reg.last;

    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !waiting_reg) else $error("scan pending at idle");
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && state_next == S_IDLE) |=> (valid_reg == '0))
        else $error("store not cleared");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(res_reg)) else $error("result changed");

endmodule
